// ===== hw/rtl/xtea_block_cipher_assert.svh =====
// Assertion macros for the XTEA block cipher checker.
// Used by xtea_checker.sv; no other dependencies.
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define XTEA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define XTEA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/xtea_pkg.sv =====
// Shared types, constants and round helpers for the XTEA block cipher.
// No dependencies.
package xtea_pkg;

  localparam int unsigned XTEA_CYCLE_COUNT = 32;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned KEY_WORDS        = 4;
  localparam int unsigned KEY_INDEX_W      = 2;

  // Round constant; adding it is the same as subtracting 0x61C88647.
  localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E3779B9;

  typedef logic [KEY_INDEX_W-1:0]               key_index_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0]     key_set_t;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
  } in_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_first_word;
    logic [WORD_W-1:0] out_second_word;
  } out_req_t;

  // One pipeline slot: a block in flight.
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } stage_t;

  // Round sum after n steps, mod 2^32 (elaboration only).
  function automatic logic [WORD_W-1:0] xtea_sum_at(input int unsigned n);
    logic [WORD_W-1:0] nn;
    nn = WORD_W'(n);
    return nn * XTEA_DELTA;
  endfunction

  function automatic logic [WORD_W-1:0] xtea_mix(input logic [WORD_W-1:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// ===== hw/rtl/xtea_keys.sv =====
// Key register file for the XTEA block cipher: four 32-bit words.
// Depends on xtea_pkg.
module xtea_keys (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  xtea_pkg::key_index_t   cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0] cfg_data,
  output xtea_pkg::key_set_t     keys
);

  xtea_pkg::key_set_t key_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_regs <= '0;
    end else if (cfg_write) begin
      key_regs[cfg_index] <= cfg_data;
    end
  end

  assign keys = key_regs;

endmodule

// ===== hw/rtl/xtea_round.sv =====
// One Feistel half-round of XTEA as a registered pipeline stage.
// Depends on xtea_pkg.
module xtea_round #(
  parameter int unsigned CYCLE_COUNT = xtea_pkg::XTEA_CYCLE_COUNT,
  parameter int unsigned STAGE       = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  xtea_pkg::key_set_t keys,
  input  xtea_pkg::stage_t   prev,
  output xtea_pkg::stage_t   curr
);

  localparam int unsigned CYC = STAGE / 2;
  localparam bit          ODD = (STAGE % 2) == 1;

  // Encrypt: even stage updates v0, odd updates v1. Decrypt runs mirrored.
  localparam logic [xtea_pkg::WORD_W-1:0] ENC_SUM =
    xtea_pkg::xtea_sum_at(ODD ? CYC + 1 : CYC);
  localparam logic [xtea_pkg::WORD_W-1:0] DEC_SUM =
    xtea_pkg::xtea_sum_at(ODD ? CYCLE_COUNT - CYC - 1 : CYCLE_COUNT - CYC);
  localparam xtea_pkg::key_index_t ENC_KEY = ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
  localparam xtea_pkg::key_index_t DEC_KEY = ODD ? DEC_SUM[1:0]   : DEC_SUM[12:11];

  logic                          upd_v1;
  logic [xtea_pkg::WORD_W-1:0]   src;
  logic [xtea_pkg::WORD_W-1:0]   dst;
  logic [xtea_pkg::WORD_W-1:0]   sum_key;
  logic [xtea_pkg::WORD_W-1:0]   f;
  logic [xtea_pkg::WORD_W-1:0]   res;
  xtea_pkg::stage_t              curr_next;

  always_comb begin
    upd_v1  = ODD ^ prev.kind;
    src     = upd_v1 ? prev.v0 : prev.v1;
    dst     = upd_v1 ? prev.v1 : prev.v0;
    sum_key = prev.kind ? (DEC_SUM + keys[DEC_KEY]) : (ENC_SUM + keys[ENC_KEY]);
    f       = xtea_pkg::xtea_mix(src) ^ sum_key;
    res     = prev.kind ? (dst - f) : (dst + f);

    curr_next       = prev;
    curr_next.v0    = upd_v1 ? prev.v0 : res;
    curr_next.v1    = upd_v1 ? res : prev.v1;
  end

  // Only the valid bit is reset; the data follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      curr.valid <= 1'b0;
    end else if (advance) begin
      curr <= curr_next;
    end
  end

endmodule

// ===== hw/rtl/xtea_block_cipher.sv =====
// XTEA 64-bit block cipher, ECB, fully pipelined top level.
// Depends on xtea_pkg, xtea_keys and xtea_round.
//
// Encrypts (kind 0) or decrypts (kind 1) one 64-bit block per request with
// the 128-bit key held in four key registers (cfg_index 0..3, reset to 0).
// The rounds are unrolled into 2*CYCLE_COUNT register stages, one Feistel
// half-round each, so a new request is taken every cycle unless the pipe is
// stalled, and its result reaches the output after passing through every
// stage register in order.
// The last stage register is the output register. When the output is held
// by out_stall the whole pipe freezes and in_stall rises; nothing is lost
// or repeated. Key words are read by every stage, so write them only while
// no request is in flight.
module xtea_block_cipher #(
  parameter int unsigned CYCLE_COUNT = xtea_pkg::XTEA_CYCLE_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  // input request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  xtea_pkg::in_req_t           in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output xtea_pkg::out_req_t          out_data,
  // key write port
  input  logic                        cfg_write,
  input  xtea_pkg::key_index_t        cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0] cfg_data
);

  localparam int unsigned STAGES = 2 * CYCLE_COUNT;

  xtea_pkg::key_set_t keys;
  xtea_pkg::stage_t   chain [0:STAGES];
  logic               advance;

  xtea_keys u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys)
  );

  // Global enable: the pipe moves unless a finished result is held.
  assign advance  = !(chain[STAGES].valid && out_stall);
  assign in_stall = !advance;

  always_comb begin
    chain[0].valid = in_valid;
    chain[0].kind  = in_data.kind;
    chain[0].v0    = in_data.first_word;
    chain[0].v1    = in_data.second_word;
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_round
    xtea_round #(
      .CYCLE_COUNT (CYCLE_COUNT),
      .STAGE       (s)
    ) u_round (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .keys    (keys),
      .prev    (chain[s]),
      .curr    (chain[s+1])
    );
  end

  assign out_valid                = chain[STAGES].valid;
  assign out_data.out_first_word  = chain[STAGES].v0;
  assign out_data.out_second_word = chain[STAGES].v1;

endmodule

// ===== hw/rtl/xtea_checker.sv =====
// Port-level checker for the XTEA block cipher, bound to the top level.
// Depends on xtea_pkg and xtea_block_cipher_assert.svh.
`include "xtea_block_cipher_assert.svh"

module xtea_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input xtea_pkg::out_req_t out_data
);

  // held result keeps its value
  `XTEA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result not held")
  // input only backs up behind a held result
  `XTEA_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "stall without backpressure")
  // pipe is empty right after reset
  `XTEA_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/xtea_tb_pkg.sv =====
// Testbench-side codes for the XTEA block cipher: request kinds and key register indexes.
// Depends on nothing; used by the result monitor and the testbench top.
`timescale 1ns / 1ps
package xtea_tb_pkg;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    KEY_WORD0,
    KEY_WORD1,
    KEY_WORD2,
    KEY_WORD3
  } key_reg_e;

endpackage

// ===== verif/xtea_block_monitor.sv =====
// Passive monitor for the XTEA block cipher: it predicts each request's block and checks the result.
// Depends on xtea_pkg (ports, delta) and xtea_tb_pkg (kind codes).
`timescale 1ns / 1ps
module xtea_block_monitor
  import xtea_pkg::*;
  import xtea_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_req_t           in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_req_t          out_data,
  input  logic              cfg_write,
  input  key_index_t        cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  output int                mismatches,
  output int                blocks_in_flight
);

  logic [WORD_W-1:0] key_copy [KEY_WORDS];
  out_req_t          cipher_blocks_q [$];
  out_req_t          want;
  int                errs = 0;
  int                result_idx = 0;

  assign mismatches = errs;

  // Feistel mixing term: (v << 4 ^ v >> 5) + v
  function automatic logic [WORD_W-1:0] feistel_term(input logic [WORD_W-1:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  function automatic out_req_t xtea_transform(input in_req_t req);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] s;
    out_req_t          res;
    y = req.first_word;
    z = req.second_word;
    if (req.kind == KIND_ENCRYPT) begin
      s = '0;
      for (int i = 0; i < XTEA_CYCLE_COUNT; i++) begin
        y += feistel_term(z) ^ (s + key_copy[s[1:0]]);
        s += XTEA_DELTA;
        z += feistel_term(y) ^ (s + key_copy[s[12:11]]);
      end
    end else begin
      s = WORD_W'(XTEA_CYCLE_COUNT) * XTEA_DELTA;
      for (int i = 0; i < XTEA_CYCLE_COUNT; i++) begin
        z -= feistel_term(y) ^ (s + key_copy[s[12:11]]);
        s -= XTEA_DELTA;
        y -= feistel_term(z) ^ (s + key_copy[s[1:0]]);
      end
    end
    res.out_first_word  = y;
    res.out_second_word = z;
    return res;
  endfunction

  task automatic note_mismatch(input string field, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
    if (errs < 20)
      $display("%0t: result %0d %s expected %h actual %h", $time, result_idx, field,
               exp_v, act_v);
    errs++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (key_copy[i]) key_copy[i] = '0;
      cipher_blocks_q.delete();
      blocks_in_flight <= 0;
    end else begin
      if (cfg_write)
        key_copy[cfg_index] = cfg_data;
      if (in_valid && !in_stall)
        cipher_blocks_q.push_back(xtea_transform(in_data));
      if (out_valid && !out_stall) begin
        if (cipher_blocks_q.size() == 0) begin
          if (errs < 20)
            $display("%0t: result %0d expected none actual %h %h", $time, result_idx,
                     out_data.out_first_word, out_data.out_second_word);
          errs++;
        end else begin
          want = cipher_blocks_q.pop_front();
          if (out_data.out_first_word !== want.out_first_word)
            note_mismatch("out_first_word", want.out_first_word, out_data.out_first_word);
          if (out_data.out_second_word !== want.out_second_word)
            note_mismatch("out_second_word", want.out_second_word, out_data.out_second_word);
        end
        result_idx++;
      end
      blocks_in_flight <= cipher_blocks_q.size();
    end
  end

endmodule

// ===== verif/xtea_block_cipher_tb.sv =====
// Top of the XTEA block cipher testbench: clock, reset, key loads, requests and verdict.
// Depends on xtea_pkg, xtea_tb_pkg, xtea_block_monitor and the xtea_block_cipher RTL.
`timescale 1ns / 1ps
module xtea_block_cipher_tb;
  import xtea_pkg::*;
  import xtea_tb_pkg::*;

  localparam int RANDOM_BLOCKS = 450;
  localparam int RANDOM_PHASES = 6;
  // one register stage per half-round
  localparam int PIPE_DEPTH    = 2 * XTEA_CYCLE_COUNT;
  // this leaves a wide margin over the slowest clean run
  localparam int CYCLE_LIMIT   = 200000;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_req_t           in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_req_t          out_data;
  logic              cfg_write = 1'b0;
  key_index_t        cfg_index = '0;
  logic [WORD_W-1:0] cfg_data  = '0;

  // quiet: no sender gaps and no output stalls
  logic quiet = 1'b0;
  int   mismatches;
  int   blocks_in_flight;
  int   cycle_count = 0;
  int   n_encrypt   = 0;
  int   n_decrypt   = 0;
  int   n_keys      = 1;   // the reset key counts as one setting

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  xtea_block_cipher uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  xtea_block_monitor monitor (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .blocks_in_flight (blocks_in_flight)
  );

  // Result side back-pressure: ~18% stall, none while quiet.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 18);
    end
  end

  // Watchdog: a hung pipe or a lost result ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d request(s) still in flight", cycle_count,
               blocks_in_flight);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // One request. Optional random gap first, then hold valid until accepted.
  // Valid stays high into the next call so back-to-back requests need no toggle.
  task automatic send_block(input logic kind, input logic [WORD_W-1:0] w0,
                            input logic [WORD_W-1:0] w1);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, first_word: w0, second_word: w1};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == KIND_ENCRYPT) n_encrypt++;
    else n_decrypt++;
  endtask

  // Same block both ways: covers both ops on each pattern it is given.
  task automatic send_both_kinds(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1);
    send_block(KIND_ENCRYPT, w0, w1);
    send_block(KIND_DECRYPT, w0, w1);
  endtask

  // Stop sending and wait for the pipe to empty. The in-flight count is
  // registered in the monitor, so the first edge here lets it catch up with
  // the last accepted request.
  task automatic drain_blocks();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blocks_in_flight != 0) @(posedge clk);
  endtask

  // Key writes only happen with the pipe empty: every stage reads the key.
  task automatic write_key(input key_reg_e idx, input logic [WORD_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                          input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
    write_key(KEY_WORD0, k0);
    write_key(KEY_WORD1, k1);
    write_key(KEY_WORD2, k2);
    write_key(KEY_WORD3, k3);
    cfg_write <= 1'b0;
    n_keys++;
  endtask

  // Mostly uniform words, with a share of zero, all-ones, single-bit and single-zero-bit patterns.
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] one_hot;
    one_hot = 32'd1 << $urandom_range(WORD_W - 1);
    case ($urandom_range(9))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return one_hot;
      end
      3: begin
        return ~one_hot;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme blocks, both kinds, under the all-zero reset key.
    send_both_kinds('0, '0);
    send_both_kinds('1, '1);
    send_both_kinds(32'hAAAAAAAA, 32'h55555555);
    send_both_kinds(32'h80000000, 32'h00000001);
    drain_blocks();

    // Same blocks under the all-ones key.
    load_key('1, '1, '1, '1);
    send_both_kinds('0, '0);
    send_both_kinds('1, '1);
    send_both_kinds(32'hAAAAAAAA, 32'h55555555);
    send_both_kinds(32'h80000000, 32'h00000001);
    drain_blocks();

    // Byte-ramp key with a text-like block and its usual ciphertext.
    load_key(32'h00010203, 32'h04050607, 32'h08090A0B, 32'h0C0D0E0F);
    send_both_kinds(32'h41424344, 32'h45464748);
    send_both_kinds(32'h497DF3D0, 32'h72612CB5);
    drain_blocks();

    // Random phases, each with its own key. Phase 1 alternates extreme key
    // words, phase 2 runs with no gaps or stalls, and in phase 3 the sender
    // holds off partway until the pipe is empty.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 1) load_key('0, '1, '0, '1);
      else load_key($urandom, $urandom, $urandom, $urandom);
      quiet <= (p == 2);
      for (int i = 0; i < RANDOM_BLOCKS / RANDOM_PHASES; i++) begin
        if (p == 3 && i == 40) drain_blocks();
        send_block(logic'($urandom_range(1)), pick_word(), pick_word());
      end
      drain_blocks();
    end
    quiet <= 1'b0;

    // Extra time catches any stray result after the last expected one.
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    $display("Checked %0d encrypt and %0d decrypt requests under %0d keys,",
             n_encrypt, n_decrypt, n_keys);
    $display("with random sender gaps and output stalls and one stretch free of both.");
    if (mismatches == 0 && blocks_in_flight == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatch(es), %0d result(s) missing", mismatches, blocks_in_flight);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
